// ----- src/keypad_scan_debounce_action_macros.svh -----
// Assertion macros for the keypad scanner.
// Needs aclk and aresetn in the scope of every use.
`ifndef KEYPAD_SCAN_DEBOUNCE_ACTION_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_ACTION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kpd_pkg.sv -----
// Shared types, phase codes and action tables for the keypad scanner.
// No dependencies.
`default_nettype none

package kpd_pkg;

    localparam int KEY_ROWS_DEF = 4;
    localparam int COL_W        = 4;

    // Debounce phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CONFIRM = 2'd1;
    localparam logic [1:0] PH_HELD    = 2'd2;
    localparam logic [1:0] PH_RELCHK  = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0] row0_cols;
        logic [COL_W-1:0] row1_cols;
        logic [COL_W-1:0] row2_cols;
        logic [COL_W-1:0] row3_cols;
        logic [COL_W-1:0] func_row_cols;
    } kpd_in_t;

    typedef struct packed {
        logic       release_event;
        logic [7:0] released_action;
        logic [7:0] held_action;
        logic [7:0] press_count;
        logic [7:0] port_out;
        logic [1:0] scan_phase;
    } kpd_out_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] action;
    } kpd_lookup_t;

    // Key row codes: row select in the high nibble, column in the low.
    function automatic kpd_lookup_t key_lookup(input logic [7:0] code);
        kpd_lookup_t res;
        res.hit = 1'b1;
        unique case (code)
            8'h11:   res.action = 8'h06;
            8'h12:   res.action = 8'h02;
            8'h14:   res.action = 8'h01;
            8'h18:   res.action = 8'h00;
            8'h21:   res.action = 8'h16;
            8'h22:   res.action = 8'h12;
            8'h24:   res.action = 8'h11;
            8'h28:   res.action = 8'h10;
            default: begin
                res.hit    = 1'b0;
                res.action = 8'h00;
            end
        endcase
        return res;
    endfunction

    function automatic kpd_lookup_t fn_lookup(input logic [7:0] code);
        kpd_lookup_t res;
        res.hit = 1'b1;
        unique case (code)
            8'h02:   res.action = 8'h0A;
            8'h04:   res.action = 8'h0B;
            8'h08:   res.action = 8'h0C;
            default: begin
                res.hit    = 1'b0;
                res.action = 8'h00;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/kpd_core.sv -----
// Debounce state machine, action lookup and port update for one sample beat.
// Depends on kpd_pkg.
`default_nettype none

module kpd_core #(
    parameter int KEY_ROWS = kpd_pkg::KEY_ROWS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire kpd_pkg::kpd_in_t  sample,
    output kpd_pkg::kpd_out_t      result
);
    import kpd_pkg::*;

    logic [1:0] phase_reg,       phase_next;
    logic [7:0] key_code_reg,    key_code_next;
    logic       func_flag_reg,   func_flag_next;
    logic [7:0] cur_act_reg,     cur_act_next;
    logic [7:0] last_act_reg,    last_act_next;
    logic [7:0] rel_cnt_reg,     rel_cnt_next;
    logic [7:0] port_bits_reg,   port_bits_next;

    logic [COL_W-1:0] rows [4];
    logic [COL_W-1:0] fcols;
    logic [COL_W-1:0] sel_cols;
    logic             any_act;
    logic             row_found;
    logic [7:0]       row_code;
    logic             still;
    logic             rel;
    kpd_lookup_t      lk;

    assign rows[0] = sample.row0_cols;
    assign rows[1] = sample.row1_cols;
    assign rows[2] = sample.row2_cols;
    assign rows[3] = sample.row3_cols;
    assign fcols   = sample.func_row_cols;

    // Columns of the row that owns the current key, first active row in idle.
    always_comb begin
        sel_cols  = func_flag_reg ? fcols : '0;
        any_act   = |fcols;
        row_found = 1'b0;
        row_code  = '0;
        for (int r = KEY_ROWS - 1; r >= 0; r--) begin
            if (!func_flag_reg && key_code_reg[4 + r]) begin
                sel_cols = sel_cols | rows[r];
            end
            if (|rows[r]) begin
                any_act   = 1'b1;
                row_found = 1'b1;
                row_code  = 8'(1 << (4 + r)) | {4'b0000, rows[r]};
            end
        end
    end

    assign still = |(sel_cols & key_code_reg[3:0]);
    assign lk    = func_flag_reg ? fn_lookup(key_code_reg) : key_lookup(key_code_reg);

    always_comb begin
        phase_next     = phase_reg;
        key_code_next  = key_code_reg;
        func_flag_next = func_flag_reg;
        cur_act_next   = cur_act_reg;
        last_act_next  = last_act_reg;
        rel_cnt_next   = rel_cnt_reg;
        rel            = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (any_act) begin
                    if (row_found) begin
                        key_code_next = row_code;
                    end else begin
                        key_code_next  = {4'b0000, fcols};
                        func_flag_next = 1'b1;
                    end
                    phase_next = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                if (still) begin
                    if (lk.hit) begin
                        cur_act_next = lk.action;
                    end
                    phase_next = PH_HELD;
                end else begin
                    func_flag_next = 1'b0;
                    phase_next     = PH_IDLE;
                end
            end
            PH_HELD: begin
                if (!still) begin
                    phase_next = PH_RELCHK;
                end
            end
            PH_RELCHK: begin
                if (still) begin
                    phase_next = PH_HELD;
                end else begin
                    rel            = 1'b1;
                    rel_cnt_next   = rel_cnt_reg + 8'd1;
                    last_act_next  = cur_act_reg;
                    func_flag_next = 1'b0;
                    cur_act_next   = '0;
                    phase_next     = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Port bit from the latched action; bit numbers past seven leave it alone.
    always_comb begin
        port_bits_next = port_bits_reg;
        if (!last_act_next[3]) begin
            port_bits_next[last_act_next[2:0]] = |last_act_next[7:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            key_code_reg  <= '0;
            func_flag_reg <= 1'b0;
            cur_act_reg   <= '0;
            last_act_reg  <= '0;
            rel_cnt_reg   <= '0;
            port_bits_reg <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            key_code_reg  <= key_code_next;
            func_flag_reg <= func_flag_next;
            cur_act_reg   <= cur_act_next;
            last_act_reg  <= last_act_next;
            rel_cnt_reg   <= rel_cnt_next;
            port_bits_reg <= port_bits_next;
        end
    end

    always_comb begin
        result.release_event   = rel;
        result.released_action = rel ? last_act_next : 8'h00;
        result.held_action     = cur_act_next;
        result.press_count     = rel_cnt_next;
        result.port_out        = port_bits_next;
        result.scan_phase      = phase_next;
    end

endmodule

`default_nettype wire

// ----- src/keypad_scan_debounce_action.sv -----
// Top level of the keypad scanner: input register, core step, result register.
// Depends on kpd_pkg, kpd_core and keypad_scan_debounce_action_macros.svh.
`default_nettype none

// One sample beat in gives one result beat out. A sample lands in the input
// register, and the debounce step runs on it and loads the result register
// as soon as that register is empty or drains. One beat per cycle is
// sustained while the output is not held: kpd_core has a single state update
// step, and the input side keeps taking beats while a result waits as long
// as the result register drains that cycle.
module keypad_scan_debounce_action #(
    parameter int KEY_ROWS = kpd_pkg::KEY_ROWS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire kpd_pkg::kpd_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kpd_pkg::kpd_out_t      m_data
);
    import kpd_pkg::*;

    logic     in_vld_reg, in_vld_next;
    kpd_in_t  in_data_reg;
    logic     out_vld_reg, out_vld_next;
    kpd_out_t out_data_reg;
    kpd_out_t step_res;
    logic     advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_res;
        end
    end

    kpd_core #(
        .KEY_ROWS (KEY_ROWS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .sample  (in_data_reg),
        .result  (step_res)
    );

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

`include "keypad_scan_debounce_action_macros.svh"

    `KPD_ASSERT_IMP(a_rel_idle, m_valid && m_data.release_event, m_data.scan_phase == PH_IDLE, "release beat not back in idle")
    `KPD_ASSERT_IMP(a_norel_zero, m_valid && !m_data.release_event, m_data.released_action == 8'h00, "released action set without release")
    `KPD_ASSERT_IMP(a_held_phase, m_valid && (m_data.held_action != 8'h00), (m_data.scan_phase == PH_HELD) || (m_data.scan_phase == PH_RELCHK), "held action outside held phases")
    `KPD_ASSERT_IMP(a_stall_cause, !s_ready, in_vld_reg && out_vld_reg && !m_ready, "input stalled without output backpressure")
    `KPD_ASSERT_NXT(a_hold_input, in_vld_reg && !advance, in_vld_reg, "pending sample dropped")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for keypad_scan_debounce_action: directed key sessions, then random ones.
// A local model of the debounce machine predicts every result beat. Needs kpd_pkg and the RTL.
`default_nettype none

module tb;
    import kpd_pkg::*;

    localparam int NUM_ROWS    = KEY_ROWS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 530;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    kpd_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    kpd_out_t m_data;

    keypad_scan_debounce_action dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // model state
    logic [1:0] st_phase = PH_IDLE;
    logic [7:0] st_code  = '0;
    logic       st_fn    = 1'b0;
    logic [7:0] st_cur   = '0;
    logic [7:0] st_last  = '0;
    logic [7:0] st_count = '0;
    logic [7:0] st_port  = '0;

    kpd_out_t expected_results[$];
    int fail_count = 0;
    int items_sent = 0;
    int cycle_cnt  = 0;
    bit src_idle   = 1'b1;
    bit sink_idle  = 1'b1;
    int sink_left  = 0;

    // {hit, action}
    function automatic logic [8:0] key_action(input logic [7:0] code);
        case (code)
            8'h11:   return {1'b1, 8'h06};
            8'h12:   return {1'b1, 8'h02};
            8'h14:   return {1'b1, 8'h01};
            8'h18:   return {1'b1, 8'h00};
            8'h21:   return {1'b1, 8'h16};
            8'h22:   return {1'b1, 8'h12};
            8'h24:   return {1'b1, 8'h11};
            8'h28:   return {1'b1, 8'h10};
            default: return 9'h000;
        endcase
    endfunction

    function automatic logic [8:0] fn_action(input logic [7:0] code);
        case (code)
            8'h02:   return {1'b1, 8'h0A};
            8'h04:   return {1'b1, 8'h0B};
            8'h08:   return {1'b1, 8'h0C};
            default: return 9'h000;
        endcase
    endfunction

    // latched key still down: its own row shares a column with the code
    function automatic bit key_down(input kpd_in_t smp);
        logic [0:4][3:0] c;
        logic [3:0]      own;
        int              r;
        c   = smp;
        own = '0;
        if (st_fn) begin
            own = c[4];
        end else begin
            for (r = 0; r < NUM_ROWS; r++)
                if (st_code[4+r]) own |= c[r];
        end
        return (own & st_code[3:0]) != 4'h0;
    endfunction

    function automatic kpd_out_t scan_step(input kpd_in_t smp);
        logic [0:4][3:0] c;
        logic [3:0]      any;
        logic [8:0]      hit;
        logic [3:0]      b;
        bit              found;
        int              r;
        kpd_out_t        o;
        c     = smp;
        o     = '0;
        found = 1'b0;
        case (st_phase)
            PH_IDLE: begin
                any = c[4];
                for (r = 0; r < NUM_ROWS; r++) any |= c[r];
                if (any != 4'h0) begin
                    for (r = 0; r < NUM_ROWS; r++) begin
                        if (!found && c[r] != 4'h0) begin
                            st_code = (8'h10 << r) | {4'h0, c[r]};
                            found   = 1'b1;
                        end
                    end
                    if (!found) begin
                        st_code = {4'h0, c[4]};
                        st_fn   = 1'b1;
                    end
                    st_phase = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                if (key_down(smp)) begin
                    hit = st_fn ? fn_action(st_code) : key_action(st_code);
                    if (hit[8]) st_cur = hit[7:0];
                    st_phase = PH_HELD;
                end else begin
                    // bounce: back to idle, function flag dropped too
                    st_fn    = 1'b0;
                    st_phase = PH_IDLE;
                end
            end
            PH_HELD: begin
                if (!key_down(smp)) st_phase = PH_RELCHK;
            end
            default: begin
                if (key_down(smp)) begin
                    st_phase = PH_HELD;
                end else begin
                    st_count = st_count + 8'd1;
                    st_last  = st_cur;
                    o.release_event   = 1'b1;
                    o.released_action = st_cur;
                    st_fn    = 1'b0;
                    st_cur   = '0;
                    st_phase = PH_IDLE;
                end
            end
        endcase
        b = st_last[3:0];
        if (b < 4'd8) begin
            if (st_last[7:4] != 4'h0) st_port = st_port | (8'h01 << b);
            else                      st_port = st_port & ~(8'h01 << b);
        end
        o.held_action = st_cur;
        o.press_count = st_count;
        o.port_out    = st_port;
        o.scan_phase  = st_phase;
        return o;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a rising edge; returns at the edge that took the beat, or after the idle gap that follows it
    task automatic send_sample(input kpd_in_t smp);
        int gap;
        s_valid <= 1'b1;
        s_data  <= smp;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        expected_results.push_back(scan_step(smp));
        items_sent++;
        if (src_idle) begin
            gap = idle_len();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // press, confirm, first release sample, release
    task automatic press_release(input kpd_in_t smp);
        send_sample(smp);
        send_sample(smp);
        send_sample('0);
        send_sample('0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0h got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // sample with key (row, cols) pressed in idle: earlier rows quiet, later ones random
    function automatic kpd_in_t press_sample(input int row, input logic [3:0] cols);
        logic [0:4][3:0] v;
        int              r;
        v = 20'($urandom);
        for (r = 0; r < 4; r++)
            if (r < row) v[r] = 4'h0;
        v[row] = cols;
        return kpd_in_t'(v);
    endfunction

    // own row keeps or loses contact with the latched columns, rest is noise
    function automatic kpd_in_t hold_sample(input int row, input logic [3:0] cols,
                                            input bit pressed);
        logic [0:4][3:0] v;
        v = 20'($urandom);
        if (pressed) v[row] = v[row] | (cols & (~cols + 4'd1));
        else         v[row] = v[row] & ~cols;
        return kpd_in_t'(v);
    endfunction

    task automatic random_session();
        int         row;
        logic [3:0] cols;
        bit         bounce;
        row    = $urandom_range(0, 4);
        cols   = ($urandom_range(0, 3) != 0) ? (4'h1 << $urandom_range(0, 3))
                                             : 4'($urandom_range(1, 15));
        bounce = ($urandom_range(0, 9) == 0);
        send_sample(press_sample(row, cols));
        send_sample(hold_sample(row, cols, !bounce));
        if (!bounce) begin
            repeat ($urandom_range(0, 4)) send_sample(hold_sample(row, cols, 1'b1));
            send_sample(hold_sample(row, cols, 1'b0));
            if ($urandom_range(0, 4) == 0) begin
                send_sample(hold_sample(row, cols, 1'b1));
                send_sample(hold_sample(row, cols, 1'b0));
            end
            send_sample(hold_sample(row, cols, 1'b0));
        end
    endtask

    task automatic test_idle_sample();
        send_sample('0);
    endtask

    task automatic test_key_press_release();
        kpd_in_t smp;
        smp = '0;
        smp.row0_cols = 4'h1;
        press_release(smp);
    endtask

    // function code 0x02 gives an action whose port bit is beyond seven
    task automatic test_function_key();
        kpd_in_t smp;
        smp = '0;
        smp.func_row_cols = 4'h2;
        press_release(smp);
    endtask

    task automatic test_confirm_bounce();
        kpd_in_t smp;
        smp = '0;
        smp.row1_cols     = 4'h4;
        smp.func_row_cols = 4'h2;
        send_sample(smp);
        send_sample('0);
    endtask

    // all columns of all rows: row 0 wins, code matches nothing
    task automatic test_unmatched_code();
        press_release('1);
    endtask

    // key comes back during release check; action sets port bit 0
    task automatic test_release_recheck();
        kpd_in_t smp;
        smp = '0;
        smp.row1_cols = 4'h8;
        send_sample(smp);
        send_sample(smp);
        send_sample('0);
        send_sample(smp);
        send_sample('0);
        send_sample('0);
    endtask

    // code 0x18 has action zero, which clears port bit 0
    task automatic test_clear_port_bit();
        kpd_in_t smp;
        smp = '0;
        smp.row0_cols = 4'h8;
        smp.row2_cols = 4'h5;
        press_release(smp);
    endtask

    task automatic test_back_to_back();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (16) random_session();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_sessions();
        int start;
        int mark;
        start = items_sent;
        mark  = items_sent;
        while (items_sent - start < RANDOM_BEATS) begin
            if ($urandom_range(0, 7) == 0) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) == 0) send_sample(kpd_in_t'(20'($urandom)));
            else                           random_session();
            if (items_sent - mark >= 120) begin
                wait_drain();
                mark = items_sent;
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    always @(posedge aclk) begin : sink_drive
        int gap;
        if (!aresetn || !sink_idle) begin
            m_ready   <= 1'b1;
            sink_left <= 0;
        end else if (sink_left != 0) begin
            m_ready   <= 1'b0;
            sink_left <= sink_left - 1;
        end else begin
            gap = idle_len();
            m_ready   <= (gap == 0);
            sink_left <= (gap != 0) ? gap - 1 : 0;
        end
    end

    // beats are compared at the falling edge before the edge that takes them
    always @(negedge aclk) begin : result_check
        kpd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("release_event",   want.release_event,   m_data.release_event);
                check_field("released_action", want.released_action, m_data.released_action);
                check_field("held_action",     want.held_action,     m_data.held_action);
                check_field("press_count",     want.press_count,     m_data.press_count);
                check_field("port_out",        want.port_out,        m_data.port_out);
                check_field("scan_phase",      want.scan_phase,      m_data.scan_phase);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_sample();
        test_key_press_release();
        test_function_key();
        test_confirm_bounce();
        test_unmatched_code();
        test_release_recheck();
        test_clear_port_bit();
        wait_drain();
        test_back_to_back();
        test_random_sessions();
        wait_drain();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
